/* src/dlstm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dlstm_pkg;

   // Fixed-point format of every datapath value: signed Q4.12.
   localparam int DATA_W        = 16;
   localparam int FRAC_BITS     = 12;
   localparam int INDEX_W       = 6;
   localparam int VECTOR_LENGTH = 64;
   // Gate and activation values lie in [-1, 1], which needs 14 signed bits.
   localparam int GATE_W        = 14;
   localparam int HIDDEN_W      = 14;
   localparam int LUT_DEPTH     = 256;
   localparam int LUT_IDX_W     = 8;

   localparam int REQ_TDATA_W   = 88;
   localparam int RSP_TDATA_W   = 40;
   localparam int RSP_TUSER_W   = 1;

   // exp(-1/32) in Q0.32, the step of the exponential recurrence.
   localparam logic [63:0] EXP_STEP_Q32 = 64'd4162825044;

   typedef logic signed [GATE_W-1:0] lut_entry_type;
   typedef lut_entry_type lut_type [LUT_DEPTH];

   // Shift-and-subtract division, only used while the tables are built.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] q16_to_qf(input logic [63:0] mag);
      return (mag + (64'd1 << (15 - FRAC_BITS))) >> (16 - FRAC_BITS);
   endfunction

   // Bin k covers [-8 + k/16, -8 + (k+1)/16) and holds the value at its midpoint.
   function automatic lut_type build_lut(input logic want_tanh);
      logic [63:0] e [2*LUT_DEPTH+1];
      logic [63:0] one;
      logic [63:0] den;
      logic [63:0] s16;
      logic [63:0] t16;
      logic [63:0] mag;
      int          d;
      int          a;
      lut_type     lut;
      one  = 64'd1 << 32;
      e[0] = one;
      for (int k = 1; k < 2*LUT_DEPTH+1; k++) begin
         e[k] = (e[k-1] * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
      end
      for (int k = 0; k < LUT_DEPTH; k++) begin
         d = 2 * k - (LUT_DEPTH - 1);
         a = (d < 0) ? -d : d;
         if (!want_tanh) begin
            den = one + e[a];
            s16 = udiv64((64'd1 << 48) + (den >> 1), den);
            if (d < 0) begin
               s16 = 64'd65536 - s16;
            end
            lut[k] = GATE_W'(q16_to_qf(s16));
         end else begin
            den = one + e[2*a];
            t16 = udiv64(((one - e[2*a]) << 16) + (den >> 1), den);
            mag = q16_to_qf(t16);
            lut[k] = (d < 0) ? GATE_W'(64'd0 - mag) : GATE_W'(mag);
         end
      end
      return lut;
   endfunction

   localparam lut_type SIGMOID_LUT = build_lut(1'b0);
   localparam lut_type TANH_LUT    = build_lut(1'b1);

endpackage

`default_nettype wire

/* src/diagonal_lstm_cell_step.sv */
`timescale 1ns / 1ps
`default_nettype none

// Diagonal-weight LSTM cell update, one state-vector element per transaction.
// The req channel carries the element index, the input sample and the four gate
// weights; the rsp channel returns the index, the new hidden value and the new
// cell value, with tuser set when the cell value was clipped.
// The datapath is a seven-register pipeline: gate products, table lookups with
// the cell-store read, cell products, cell sum and store write, tanh lookup,
// hidden product and the output register. One transaction per cycle is
// accepted when neither back-pressure nor the interlock stalls. Two
// transactions for the same index are held apart by an interlock at the store
// read, which holds the younger one in stage 1 while the older one is in
// stage 2 or 3; distinct indices flow at full rate.
// When rsp_tready is low the pipeline closes up its empty stages and then
// holds; req_tready falls once every stage is full or the interlock holds stage 1.
// Reset empties the pipeline and marks every cell-store entry as zero; the
// block takes transactions in the first cycle after reset.
module diagonal_lstm_cell_step
   import dlstm_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   // element_index, sample_in, weight_input_gate, weight_forget_gate,
   // weight_candidate, weight_output_gate, zero pad
   input  wire  [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   // result_index, hidden_out, cell_out, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // cell_saturated
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   localparam int PROD_W   = 2 * DATA_W;
   localparam int CELLP_W  = GATE_W + DATA_W;
   localparam int CANDP_W  = 2 * GATE_W;
   localparam int SUM_W    = CELLP_W + 1;
   localparam int SUMSH_W  = SUM_W - FRAC_BITS;
   localparam int ARGSH_W  = PROD_W - FRAC_BITS;
   localparam int HIDSH_W  = CANDP_W - FRAC_BITS;

   function automatic logic signed [DATA_W-1:0] sat_arg(input logic signed [ARGSH_W-1:0] v);
      logic ovf;
      ovf = (v[ARGSH_W-1:DATA_W-1] != {(ARGSH_W-DATA_W+1){v[ARGSH_W-1]}});
      if (ovf) begin
         return v[ARGSH_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
      return v[DATA_W-1:0];
   endfunction

   // The table index is the top eight bits of the Q4.12 value, offset by half range.
   function automatic logic [LUT_IDX_W-1:0] lut_index(input logic signed [DATA_W-1:0] v);
      return {~v[DATA_W-1], v[DATA_W-2:DATA_W-LUT_IDX_W]};
   endfunction

   // Input field slices.
   logic [INDEX_W-1:0]       req_index;
   logic signed [DATA_W-1:0] req_sample;
   logic signed [DATA_W-1:0] req_w_ig;
   logic signed [DATA_W-1:0] req_w_fg;
   logic signed [DATA_W-1:0] req_w_cd;
   logic signed [DATA_W-1:0] req_w_og;

   assign req_index  = req_tdata[INDEX_W-1:0];
   assign req_sample = req_tdata[INDEX_W +: DATA_W];
   assign req_w_ig   = req_tdata[INDEX_W + DATA_W +: DATA_W];
   assign req_w_fg   = req_tdata[INDEX_W + 2*DATA_W +: DATA_W];
   assign req_w_cd   = req_tdata[INDEX_W + 3*DATA_W +: DATA_W];
   assign req_w_og   = req_tdata[INDEX_W + 4*DATA_W +: DATA_W];

   // Stage valid bits and flow control.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic f1, f2, f3, f4, f5, f6, f7;
   logic hazard;
   logic move12;

   // Stage 1: gate argument products.
   logic [INDEX_W-1:0]       s1_index_ff;
   logic signed [PROD_W-1:0] s1_p_ig_ff, s1_p_fg_ff, s1_p_cd_ff, s1_p_og_ff;

   // Stage 2: gate values and the old cell value.
   logic [INDEX_W-1:0]       s2_index_ff;
   logic signed [GATE_W-1:0] s2_ig_ff, s2_fg_ff, s2_cd_ff, s2_og_ff;
   logic signed [DATA_W-1:0] s2_old_raw_ff;
   logic                     s2_old_valid_ff;
   logic signed [DATA_W-1:0] s2_old;

   // Stage 3: cell products.
   logic [INDEX_W-1:0]        s3_index_ff;
   logic signed [CELLP_W-1:0] s3_p_fo_ff;
   logic signed [CANDP_W-1:0] s3_p_ic_ff;
   logic signed [GATE_W-1:0]  s3_og_ff;

   // Stage 4: new cell value.
   logic [INDEX_W-1:0]       s4_index_ff;
   logic signed [DATA_W-1:0] s4_cell_ff;
   logic                     s4_sat_ff;
   logic signed [GATE_W-1:0] s4_og_ff;
   logic signed [SUM_W-1:0]  cell_sum;
   logic signed [SUMSH_W-1:0] cell_shift;
   logic signed [DATA_W-1:0] cell_in;
   logic                     sat_in;

   // Stage 5: tanh of the new cell.
   logic [INDEX_W-1:0]       s5_index_ff;
   logic signed [DATA_W-1:0] s5_cell_ff;
   logic                     s5_sat_ff;
   logic signed [GATE_W-1:0] s5_og_ff;
   logic signed [GATE_W-1:0] s5_tc_ff;

   // Stage 6: hidden product.
   logic [INDEX_W-1:0]        s6_index_ff;
   logic signed [DATA_W-1:0]  s6_cell_ff;
   logic                      s6_sat_ff;
   logic signed [CANDP_W-1:0] s6_p_hid_ff;

   // Stage 7: output register.
   logic [INDEX_W-1:0]         s7_index_ff;
   logic signed [DATA_W-1:0]   s7_cell_ff;
   logic                       s7_sat_ff;
   logic signed [HIDDEN_W-1:0] s7_hidden_ff;
   logic signed [HIDSH_W-1:0]  hid_shift;
   logic signed [HIDDEN_W-1:0] hidden_in;

   // Cell store with one valid bit per entry; an entry never written reads as zero.
   logic [DATA_W-1:0]        cell_mem [VECTOR_LENGTH];
   logic [VECTOR_LENGTH-1:0] cell_written_ff;
   logic                     mem_write;

   assign f7 = !v7_ff || rsp_tready;
   assign f6 = !v6_ff || f7;
   assign f5 = !v5_ff || f6;
   assign f4 = !v4_ff || f5;
   assign f3 = !v3_ff || f4;
   assign f2 = !v2_ff || f3;

   // An item must not read the store while an older item for the same index
   // has yet to write it back.
   assign hazard = (v2_ff && (s2_index_ff == s1_index_ff)) ||
                   (v3_ff && (s3_index_ff == s1_index_ff));
   assign move12 = v1_ff && f2 && !hazard;
   assign f1     = !v1_ff || move12;

   assign req_tready = f1;
   assign mem_write  = v3_ff && f4;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         if (f1) v1_ff <= req_tvalid;
         if (f2) v2_ff <= move12;
         if (f3) v3_ff <= v2_ff;
         if (f4) v4_ff <= v3_ff;
         if (f5) v5_ff <= v4_ff;
         if (f6) v6_ff <= v5_ff;
         if (f7) v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_written_ff <= '0;
      end else if (mem_write) begin
         cell_written_ff[s3_index_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_write) begin
         cell_mem[s3_index_ff] <= cell_in;
      end
      if (f2) begin
         s2_old_raw_ff <= cell_mem[s1_index_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (f2) begin
         s2_old_valid_ff <= cell_written_ff[s1_index_ff];
      end
   end

   assign s2_old = s2_old_valid_ff ? s2_old_raw_ff : '0;

   // Cell sum; the arithmetic shift floors toward minus infinity.
   assign cell_sum   = SUM_W'(s3_p_fo_ff) + SUM_W'(s3_p_ic_ff);
   assign cell_shift = cell_sum[SUM_W-1:FRAC_BITS];
   assign sat_in     = (cell_shift[SUMSH_W-1:DATA_W-1] !=
                        {(SUMSH_W-DATA_W+1){cell_shift[SUMSH_W-1]}});
   assign cell_in    = !sat_in ? cell_shift[DATA_W-1:0] :
                       cell_shift[SUMSH_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} :
                                               {1'b0, {(DATA_W-1){1'b1}}};

   assign hid_shift = s6_p_hid_ff[CANDP_W-1:FRAC_BITS];
   assign hidden_in = (hid_shift[HIDSH_W-1:HIDDEN_W-1] ==
                       {(HIDSH_W-HIDDEN_W+1){hid_shift[HIDSH_W-1]}}) ?
                      hid_shift[HIDDEN_W-1:0] :
                      hid_shift[HIDSH_W-1] ? {1'b1, {(HIDDEN_W-1){1'b0}}} :
                                             {1'b0, {(HIDDEN_W-1){1'b1}}};

   always_ff @(posedge clock) begin
      if (f1) begin
         s1_index_ff <= req_index;
         s1_p_ig_ff  <= req_sample * req_w_ig;
         s1_p_fg_ff  <= req_sample * req_w_fg;
         s1_p_cd_ff  <= req_sample * req_w_cd;
         s1_p_og_ff  <= req_sample * req_w_og;
      end
      if (f2) begin
         s2_index_ff <= s1_index_ff;
         s2_ig_ff    <= SIGMOID_LUT[lut_index(sat_arg(s1_p_ig_ff[PROD_W-1:FRAC_BITS]))];
         s2_fg_ff    <= SIGMOID_LUT[lut_index(sat_arg(s1_p_fg_ff[PROD_W-1:FRAC_BITS]))];
         s2_cd_ff    <= TANH_LUT[lut_index(sat_arg(s1_p_cd_ff[PROD_W-1:FRAC_BITS]))];
         s2_og_ff    <= SIGMOID_LUT[lut_index(sat_arg(s1_p_og_ff[PROD_W-1:FRAC_BITS]))];
      end
      if (f3) begin
         s3_index_ff <= s2_index_ff;
         s3_p_fo_ff  <= s2_fg_ff * s2_old;
         s3_p_ic_ff  <= s2_ig_ff * s2_cd_ff;
         s3_og_ff    <= s2_og_ff;
      end
      if (f4) begin
         s4_index_ff <= s3_index_ff;
         s4_cell_ff  <= cell_in;
         s4_sat_ff   <= sat_in;
         s4_og_ff    <= s3_og_ff;
      end
      if (f5) begin
         s5_index_ff <= s4_index_ff;
         s5_cell_ff  <= s4_cell_ff;
         s5_sat_ff   <= s4_sat_ff;
         s5_og_ff    <= s4_og_ff;
         s5_tc_ff    <= TANH_LUT[lut_index(s4_cell_ff)];
      end
      if (f6) begin
         s6_index_ff <= s5_index_ff;
         s6_cell_ff  <= s5_cell_ff;
         s6_sat_ff   <= s5_sat_ff;
         s6_p_hid_ff <= s5_og_ff * s5_tc_ff;
      end
      if (f7) begin
         s7_index_ff  <= s6_index_ff;
         s7_cell_ff   <= s6_cell_ff;
         s7_sat_ff    <= s6_sat_ff;
         s7_hidden_ff <= hidden_in;
      end
   end

   assign rsp_tvalid = v7_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-INDEX_W-HIDDEN_W-DATA_W){1'b0}},
                        s7_cell_ff, s7_hidden_ff, s7_index_ff};
   assign rsp_tuser  = s7_sat_ff;

endmodule

`default_nettype wire

/* test/tb_diagonal_lstm_cell_step.sv */
`timescale 1ns / 1ps

module tb_diagonal_lstm_cell_step;

   localparam int FRAC           = 12;
   localparam int TABLE_SIZE     = 256;
   localparam int CELL_COUNT     = 64;
   localparam int RANDOM_ITEMS   = 500;
   localparam int IDLE_PERCENT   = 31;
   localparam int CALM_FIRST     = 200;
   localparam int CALM_LAST      = 299;
   localparam int DRAIN_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   // exp(-1/32) in Q0.32; successive powers give the activation tables.
   localparam longint unsigned EXP_DECAY_Q32 = 64'd4162825044;

   typedef enum int {
      MIX_ANY,
      MIX_IN_RANGE,
      MIX_GROW_CELL
   } stimulus_mix_type;

   typedef struct packed {
      logic [5:0]         element_index;
      logic signed [15:0] sample_in;
      logic signed [15:0] weight_input_gate;
      logic signed [15:0] weight_forget_gate;
      logic signed [15:0] weight_candidate;
      logic signed [15:0] weight_output_gate;
   } cell_req_type;

   typedef struct packed {
      logic [5:0]         result_index;
      logic signed [13:0] hidden_out;
      logic signed [15:0] cell_out;
      logic               cell_saturated;
   } cell_rsp_type;

   class lstm_cell_scoreboard;
      int unsigned  error_count;
      int           sigmoid_table[TABLE_SIZE];
      int           tanh_table[TABLE_SIZE];
      int           cell_mem[CELL_COUNT];
      cell_rsp_type expected_q[$];

      function new();
         longint unsigned e[2*TABLE_SIZE+1];
         longint unsigned one;
         longint unsigned den;
         longint unsigned s16;
         longint unsigned t16;
         int              d;
         int              a;
         int              mag;
         error_count = 0;
         one  = 64'd1 << 32;
         e[0] = one;
         for (int k = 1; k < 2*TABLE_SIZE+1; k++) begin
            e[k] = (e[k-1] * EXP_DECAY_Q32 + (64'd1 << 31)) >> 32;
         end
         // Each bin holds the function value at its midpoint, (2k - 255) / 32.
         for (int k = 0; k < TABLE_SIZE; k++) begin
            d   = 2 * k - (TABLE_SIZE - 1);
            a   = (d < 0) ? -d : d;
            den = one + e[a];
            s16 = ((64'd1 << 48) + den / 2) / den;
            if (d < 0) begin
               s16 = 64'd65536 - s16;
            end
            sigmoid_table[k] = int'((s16 + (64'd1 << (15 - FRAC))) >> (16 - FRAC));
            den = one + e[2*a];
            t16 = (((one - e[2*a]) << 16) + den / 2) / den;
            mag = int'((t16 + (64'd1 << (15 - FRAC))) >> (16 - FRAC));
            tanh_table[k] = (d < 0) ? -mag : mag;
         end
         foreach (cell_mem[i]) begin
            cell_mem[i] = 0;
         end
      endfunction

      function int clip(longint v, int lo, int hi);
         if (v < lo) begin
            return lo;
         end
         if (v > hi) begin
            return hi;
         end
         return int'(v);
      endfunction

      function int gate_argument(logic signed [15:0] x, logic signed [15:0] w);
         return clip((longint'(x) * longint'(w)) >>> FRAC, -32768, 32767);
      endfunction

      function int activation(bit want_tanh, int x);
         int offset;
         int bin;
         offset = x + (128 << (FRAC - 4));
         bin    = (offset < 0) ? 0 : (offset >>> (FRAC - 4));
         if (bin > TABLE_SIZE - 1) begin
            bin = TABLE_SIZE - 1;
         end
         return want_tanh ? tanh_table[bin] : sigmoid_table[bin];
      endfunction

      function void note_request(cell_req_type r);
         int           input_gate;
         int           forget_gate;
         int           candidate;
         int           output_gate;
         longint       cell_sum;
         int           new_cell;
         int           hidden;
         cell_rsp_type exp_rsp;
         input_gate  = activation(1'b0, gate_argument(r.sample_in, r.weight_input_gate));
         forget_gate = activation(1'b0, gate_argument(r.sample_in, r.weight_forget_gate));
         candidate   = activation(1'b1, gate_argument(r.sample_in, r.weight_candidate));
         output_gate = activation(1'b0, gate_argument(r.sample_in, r.weight_output_gate));
         cell_sum = (longint'(forget_gate) * cell_mem[r.element_index]
                     + longint'(input_gate) * candidate) >>> FRAC;
         new_cell = clip(cell_sum, -32768, 32767);
         cell_mem[r.element_index] = new_cell;
         hidden = clip((longint'(output_gate) * activation(1'b1, new_cell)) >>> FRAC,
                       -8192, 8191);
         exp_rsp.result_index   = r.element_index;
         exp_rsp.hidden_out     = 14'(hidden);
         exp_rsp.cell_out       = 16'(new_cell);
         exp_rsp.cell_saturated = (longint'(new_cell) != cell_sum);
         expected_q.push_back(exp_rsp);
      endfunction

      function void check_result(cell_rsp_type got);
         cell_rsp_type exp_rsp;
         if (expected_q.size() == 0) begin
            $error("rsp transaction with nothing expected: index %0d", got.result_index);
            error_count++;
            return;
         end
         exp_rsp = expected_q.pop_front();
         if (got.result_index !== exp_rsp.result_index) begin
            $error("result_index: expected %0d, got %0d",
                   exp_rsp.result_index, got.result_index);
            error_count++;
         end
         if (got.hidden_out !== exp_rsp.hidden_out) begin
            $error("hidden_out: expected %0d, got %0d", exp_rsp.hidden_out, got.hidden_out);
            error_count++;
         end
         if (got.cell_out !== exp_rsp.cell_out) begin
            $error("cell_out: expected %0d, got %0d", exp_rsp.cell_out, got.cell_out);
            error_count++;
         end
         if (got.cell_saturated !== exp_rsp.cell_saturated) begin
            $error("cell_saturated: expected %0d, got %0d",
                   exp_rsp.cell_saturated, got.cell_saturated);
            error_count++;
         end
      endfunction

      function int unsigned outstanding();
         return expected_q.size();
      endfunction
   endclass

   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [dlstm_pkg::REQ_TDATA_W-1:0]   req_tdata  = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [dlstm_pkg::RSP_TDATA_W-1:0]   rsp_tdata;
   logic [dlstm_pkg::RSP_TUSER_W-1:0]   rsp_tuser;

   lstm_cell_scoreboard sb;
   int                  requests_sent = 0;
   int                  results_seen  = 0;

   diagonal_lstm_cell_step u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   task automatic send_request(input cell_req_type r);
      bit calm;
      calm = (requests_sent >= CALM_FIRST) && (requests_sent <= CALM_LAST);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, r.weight_output_gate, r.weight_candidate, r.weight_forget_gate,
                     r.weight_input_gate, r.sample_in, r.element_index};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sb.note_request(r);
      requests_sent++;
   endtask

   function automatic cell_req_type make_request(stimulus_mix_type mix);
      cell_req_type r;
      r.element_index      = $urandom_range(0, 63);
      r.sample_in          = $urandom;
      r.weight_input_gate  = $urandom;
      r.weight_forget_gate = $urandom;
      r.weight_candidate   = $urandom;
      r.weight_output_gate = $urandom;
      case (mix)
         MIX_IN_RANGE: begin
            // A sample within one keeps every gate argument inside the tables.
            r.sample_in = $urandom_range(0, 8191) - 4096;
            if ($urandom_range(0, 1) == 0) begin
               r.element_index = $urandom_range(0, 3);
            end
         end
         MIX_GROW_CELL: begin
            // Strong gates on a few indices drive the stored cell into its limits.
            r.element_index      = $urandom_range(0, 3);
            r.sample_in          = $urandom_range(16384, 32767);
            r.weight_input_gate  = $urandom_range(8192, 32767);
            r.weight_forget_gate = $urandom_range(8192, 32767);
            r.weight_output_gate = $urandom_range(0, 65535);
            if ($urandom_range(0, 1) == 0) begin
               r.weight_candidate = $urandom_range(8192, 32767);
            end else begin
               r.weight_candidate = -$urandom_range(8192, 32768);
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result({rsp_tdata[5:0], rsp_tdata[19:6], rsp_tdata[35:20], rsp_tuser[0]});
            results_seen++;
         end
         if (results_seen >= CALM_FIRST && results_seen <= CALM_LAST) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   initial begin
      int stalled_cycles;
      stalled_cycles = 0;
      while (stalled_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stalled_cycles = 0;
         end else begin
            stalled_cycles++;
         end
      end
      $display("tb_diagonal_lstm_cell_step: done, errors");
      $finish;
   end

   initial begin
      cell_req_type     r;
      int               pick;
      stimulus_mix_type mix;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Extremes: zero everywhere, then full-scale products of both signs.
      send_request('{6'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
      send_request('{6'd63, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
      send_request('{6'd63, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
      send_request('{6'd1, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
      send_request('{6'd2, 16'sd4096, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
      send_request('{6'd2, 16'sd4096, 16'sd1, 16'shffff, 16'sd2048, 16'sh8000});
      // Repeated updates of one index walk the cell up to its positive limit.
      repeat (10) begin
         send_request('{6'd5, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
      end
      // Same again toward the negative limit, then a closed forget gate.
      repeat (8) begin
         send_request('{6'd6, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff});
      end
      send_request('{6'd6, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});

      repeat (RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            mix = MIX_ANY;
         end else if (pick < 75) begin
            mix = MIX_IN_RANGE;
         end else begin
            mix = MIX_GROW_CELL;
         end
         r = make_request(mix);
         send_request(r);
      end
      req_tvalid <= 1'b0;

      while (sb.outstanding() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0) begin
         $display("tb_diagonal_lstm_cell_step: done, clean");
      end else begin
         $display("tb_diagonal_lstm_cell_step: done, errors");
      end
      $finish;
   end

endmodule
